// File: rtl/cnle_pkg.sv
// shared types and constants of the corner near line end filter
package cnle_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_TEST  = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MIN_LEN   = 2'd1;
  localparam logic [1:0] REG_NEAR_DIST = 2'd2;

  localparam int RESP_W  = 32;
  localparam int DIST_W  = 23;
  localparam int COUNT_W = 7;
  localparam int OUT_W   = 16;

  localparam logic signed [RESP_W-1:0] THRESHOLD_RST = 32'sd168;
  localparam logic [DIST_W-1:0]        MIN_LEN_RST   = 23'd40000;
  localparam logic [DIST_W-1:0]        NEAR_DIST_RST = 23'd400;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    above;
    logic    tbl_empty;
    logic    scan_last;
    logic    pipe_busy;
    logic    out_free;
  } sts_t;

endpackage

// File: rtl/cnle_ctrl.sv
// controller state machine of the corner near line end filter
module cnle_ctrl
  import cnle_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        if (sts.opcode == OP_TEST && sts.above && !sts.tbl_empty) state_nxt = ST_SCAN;
        else state_nxt = ST_FINISH;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_FINISH: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// File: rtl/cnle_datapath.sv
// configuration and item registers, segment memory, distance pipeline and result register
module cnle_datapath
  import cnle_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_BITS   = 11,
  parameter int IN_W         = 104
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [IN_W-1:0] in_tdata,
  input  logic            cfg_valid,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [OUT_W-1:0] out_tdata,
  input  cmd_t            cmd,
  output sts_t            sts
);

  localparam int CW    = COORD_BITS;
  localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int SQ_W  = 2 * CW;
  localparam int DSQ_W = 2 * CW + 1;
  localparam int CMP_W = (DSQ_W > DIST_W) ? DSQ_W : DIST_W;

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // configuration
  logic signed [RESP_W-1:0] thresh_r;
  logic [DIST_W-1:0]        min_len_r;
  logic [DIST_W-1:0]        near_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= THRESHOLD_RST;
      min_len_r <= MIN_LEN_RST;
      near_r    <= NEAR_DIST_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD: thresh_r  <= $signed(cfg_data);
        REG_MIN_LEN:   min_len_r <= cfg_data[DIST_W-1:0];
        REG_NEAR_DIST: near_r    <= cfg_data[DIST_W-1:0];
        default:       ;
      endcase
    end
  end

  // item register
  opcode_t                  op_r;
  logic [CW-1:0]            sx0_r, sy0_r, sx1_r, sy1_r, px_r, py_r;
  logic signed [RESP_W-1:0] resp_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= opcode_t'(in_tdata[1:0]);
      sx0_r  <= in_tdata[2+0*CW +: CW];
      sy0_r  <= in_tdata[2+1*CW +: CW];
      sx1_r  <= in_tdata[2+2*CW +: CW];
      sy1_r  <= in_tdata[2+3*CW +: CW];
      px_r   <= in_tdata[2+4*CW +: CW];
      py_r   <= in_tdata[2+5*CW +: CW];
      resp_r <= $signed(in_tdata[2+6*CW +: RESP_W]);
    end
  end

  logic above;
  assign above = (resp_r > thresh_r);

  // segment table
  logic [4*CW-1:0] seg_mem [MAX_SEGMENTS];
  logic [4*CW-1:0] rd_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0]    idx_r;
  logic             full;
  logic             do_add;

  assign full   = (count_r == CNT_W'(MAX_SEGMENTS));
  assign do_add = cmd.commit && (op_r == OP_ADD) && !full;

  always_ff @(posedge clk) begin
    if (do_add) begin
      seg_mem[count_r[AW-1:0]] <= {sy1_r, sx1_r, sy0_r, sx0_r};
    end
    if (cmd.scan) begin
      rd_r <= seg_mem[idx_r];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (op_r == OP_CLEAR) count_nxt = '0;
    else if (do_add) count_nxt = count_r + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.scan) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  // distance pipeline: read word, squares, compare and accumulate
  logic            v1_r, v2_r;
  logic [SQ_W-1:0] lx_sq_r, ly_sq_r, ax_sq_r, ay_sq_r, bx_sq_r, by_sq_r;
  logic [CW-1:0]   ex0, ey0, ex1, ey1;
  logic [CW-1:0]   lx, ly, ax, ay, bx, by;

  assign ex0 = rd_r[0*CW +: CW];
  assign ey0 = rd_r[1*CW +: CW];
  assign ex1 = rd_r[2*CW +: CW];
  assign ey1 = rd_r[3*CW +: CW];
  assign lx  = abs_diff(ex0, ex1);
  assign ly  = abs_diff(ey0, ey1);
  assign ax  = abs_diff(ex0, px_r);
  assign ay  = abs_diff(ey0, py_r);
  assign bx  = abs_diff(ex1, px_r);
  assign by  = abs_diff(ey1, py_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      lx_sq_r <= SQ_W'(lx) * SQ_W'(lx);
      ly_sq_r <= SQ_W'(ly) * SQ_W'(ly);
      ax_sq_r <= SQ_W'(ax) * SQ_W'(ax);
      ay_sq_r <= SQ_W'(ay) * SQ_W'(ay);
      bx_sq_r <= SQ_W'(bx) * SQ_W'(bx);
      by_sq_r <= SQ_W'(by) * SQ_W'(by);
    end
  end

  logic [DSQ_W-1:0] len_sq, a_sq, b_sq;
  logic             seg_hit;
  logic             hit_r;

  assign len_sq  = DSQ_W'(lx_sq_r) + DSQ_W'(ly_sq_r);
  assign a_sq    = DSQ_W'(ax_sq_r) + DSQ_W'(ay_sq_r);
  assign b_sq    = DSQ_W'(bx_sq_r) + DSQ_W'(by_sq_r);
  assign seg_hit = (CMP_W'(len_sq) >= CMP_W'(min_len_r)) &&
                   ((CMP_W'(a_sq) < CMP_W'(near_r)) || (CMP_W'(b_sq) < CMP_W'(near_r)));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_r <= 1'b0;
    end else if (v2_r && seg_hit) begin
      hit_r <= 1'b1;
    end
  end

  // result register
  logic out_valid_r;
  logic keep_r, above_r, ovf_r;
  logic [COUNT_W-1:0] cnt_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      keep_r    <= (op_r == OP_TEST) && above && hit_r;
      above_r   <= (op_r == OP_TEST) && above;
      ovf_r     <= (op_r == OP_ADD) && full;
      cnt_out_r <= COUNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-COUNT_W-3){1'b0}}, cnt_out_r, ovf_r, above_r, keep_r};

  assign sts.opcode    = op_r;
  assign sts.above     = above;
  assign sts.tbl_empty = (count_r == '0);
  assign sts.scan_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign sts.pipe_busy = v1_r || v2_r;
  assign sts.out_free  = !out_valid_r || out_tready;

endmodule

// File: rtl/corner_near_line_end_filter.sv
// corner near line end filter: top level
//
// keeps a table of up to MAX_SEGMENTS line segments and filters corner pixels
// against the endpoints of the long ones.
// in_* stream: one word per item; opcode clear, add segment, test pixel or no-op.
// out_* stream: exactly one result word per input word, in order.
// cfg_* port: register writes (threshold, min squared length, near squared
// distance), always ready; write only while no item is in flight.
// sequence: clear, add and tests that need no table walk go from accept
// through dispatch to commit; a test above threshold on a non-empty table
// walks the segment memory through its single read port, one entry a cycle,
// into a two stage distance pipeline, and commits once that pipeline drains.
// one item is worked on at a time; a new word is taken while the previous
// result still sits in the output register.
// if the receiver stalls, the result is held and the finished item waits
// before committing, so nothing is lost.
// reset empties the table and loads the register defaults; table contents
// are not cleared, entries beyond the count are never read.
module corner_near_line_end_filter
  import cnle_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_BITS   = 11
) (
  input  logic clk,
  input  logic rst_n,
  // opcode, seg_x0, seg_y0, seg_x1, seg_y1, pixel_x, pixel_y, response
  input  logic [((2 + 6 * COORD_BITS + RESP_W + 7) / 8) * 8 - 1:0] in_tdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  // keep_pixel, above_threshold, table_overflow, segment_count
  output logic [OUT_W-1:0]  out_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int IN_W = ((2 + 6 * COORD_BITS + RESP_W + 7) / 8) * 8;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  cnle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cnle_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .COORD_BITS   (COORD_BITS),
    .IN_W         (IN_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// File: rtl/cnle_checker.sv
// port level checks of the corner near line end filter, bound to the top level
module cnle_checker
  import cnle_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed under stall");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && !out_tdata[1]))
    else $error("pixel kept below threshold");

  // a dropped add only happens on a full table
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[9:3] == COUNT_W'(MAX_SEGMENTS))
    else $error("overflow flagged with table not full");

endmodule

bind corner_near_line_end_filter cnle_checker #(
  .MAX_SEGMENTS (MAX_SEGMENTS)
) u_cnle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
